// ===== src/chassis_motion_pattern_sequencer_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the chassis motion pattern sequencer
// Shared assertion forms. They expect clk and rst in the scope where they
// are used.
// ----------------------------------------------------------------------------
`ifndef CHASSIS_MOTION_PATTERN_SEQUENCER_TOP_MACROS_SVH
`define CHASSIS_MOTION_PATTERN_SEQUENCER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CMPS_CHECK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CMPS_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after reset is seen.
`define CMPS_CHECK_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

// ===== src/cmps_pkg.sv =====
// ----------------------------------------------------------------------------
// Chassis motion pattern sequencer package
// Action and mode codes, pattern timing constants and shared types.
// ----------------------------------------------------------------------------
package cmps_pkg;

  typedef enum logic [2:0] {
    ACT_REQUEST     = 3'd0,
    ACT_TICK        = 3'd1,
    ACT_MANUAL      = 3'd2,
    ACT_MANUAL_TICK = 3'd3,
    ACT_STOP        = 3'd4
  } action_t;

  typedef enum logic [3:0] {
    MODE_OFF       = 4'd0,
    MODE_IDLE      = 4'd1,
    MODE_SLEEP     = 4'd2,
    MODE_GREET     = 4'd3,
    MODE_ATTENTION = 4'd4,
    MODE_CELEBRATE = 4'd5,
    MODE_DIZZY     = 4'd6,
    MODE_THINKING  = 4'd7,
    MODE_HEART     = 4'd8
  } mode_t;

  // Gripper angles.
  localparam logic [7:0] ANGLE_CLOSED = 8'd0;
  localparam logic [7:0] ANGLE_MID    = 8'd90;
  localparam logic [7:0] ANGLE_OPEN   = 8'd180;

  // Manual override hold time.
  localparam logic [31:0] MANUAL_HOLD_MS = 32'd1500;

  // Greet: open/close flaps for a fixed time, then settle once.
  localparam logic [31:0] GREET_LENGTH  = 32'd480;
  localparam logic [7:0]  GREET_PERIOD  = 8'd240;
  localparam logic [7:0]  GREET_HALF    = 8'd120;

  // Attention: forward, back, pause.
  localparam logic [9:0]  ATTN_PERIOD   = 10'd1000;
  localparam logic [9:0]  ATTN_FWD_END  = 10'd200;
  localparam logic [9:0]  ATTN_BACK_END = 10'd400;
  localparam logic signed [7:0] ATTN_SPEED = 8'sd50;

  // Celebrate: eight beats of 300 ms.
  localparam logic [11:0] CELEB_PERIOD  = 12'd2400;
  localparam logic signed [7:0] CELEB_SPIN      = 8'sd90;
  localparam logic signed [7:0] CELEB_SPIN_HALF = 8'sd45;

  // Dizzy: alternating spin until the run ends.
  localparam logic [31:0] DIZZY_LENGTH  = 32'd2400;
  localparam logic [9:0]  DIZZY_PERIOD  = 10'd600;
  localparam logic [9:0]  DIZZY_HALF    = 10'd300;
  localparam logic signed [7:0] DIZZY_SPIN = 8'sd40;

  // Thinking: short strafe one way, pause, short strafe back, pause.
  localparam logic [10:0] THINK_PERIOD    = 11'd1600;
  localparam logic [10:0] THINK_NUDGE     = 11'd120;
  localparam logic [10:0] THINK_BACK_BEG  = 11'd800;
  localparam logic [10:0] THINK_BACK_END  = 11'd920;
  localparam logic signed [7:0] THINK_SPEED = 8'sd30;

  // Heart: slow gripper pulse.
  localparam logic [10:0] HEART_PERIOD  = 11'd1200;
  localparam logic [10:0] HEART_HALF    = 11'd600;

  // 2^32 modulo each period. When the 32-bit elapsed time wraps, this much
  // is missing from the plain difference of the two positions.
  localparam logic [7:0]  WRAP_240  = 8'd16;
  localparam logic [9:0]  WRAP_1000 = 10'd296;
  localparam logic [9:0]  WRAP_600  = 10'd496;
  localparam logic [10:0] WRAP_1600 = 11'd896;
  localparam logic [10:0] WRAP_1200 = 11'd496;
  localparam logic [11:0] WRAP_2400 = 12'd1696;

  // One input word as it travels down the pipeline.
  typedef struct packed {
    logic [2:0]         action;
    logic [3:0]         motion;
    logic [31:0]        now_ms;
    logic signed [7:0]  w0;
    logic signed [7:0]  w1;
    logic signed [7:0]  w2;
    logic signed [7:0]  w3;
  } item_t;

  // Time positions within each pattern period.
  typedef struct packed {
    logic [7:0]  r240;
    logic [9:0]  r1000;
    logic [9:0]  r600;
    logic [10:0] r1600;
    logic [10:0] r1200;
    logic [11:0] r2400;
  } residue_t;

  // Celebrate beat number from the position within its 2400 ms period.
  function automatic logic [2:0] beat_of(input logic [11:0] p);
    logic [2:0] b;
    if (p < 12'd300)       b = 3'd0;
    else if (p < 12'd600)  b = 3'd1;
    else if (p < 12'd900)  b = 3'd2;
    else if (p < 12'd1200) b = 3'd3;
    else if (p < 12'd1500) b = 3'd4;
    else if (p < 12'd1800) b = 3'd5;
    else if (p < 12'd2100) b = 3'd6;
    else                   b = 3'd7;
    return b;
  endfunction

  // Elapsed time modulo a period from the positions of now and of the phase
  // start. When the 32-bit elapsed time wrapped, 2^32 modulo the period is
  // added back.
  function automatic logic [11:0] period_diff(input logic [11:0] now_pos,
                                              input logic [11:0] start_pos,
                                              input logic [11:0] period,
                                              input logic [11:0] wrap_add,
                                              input logic        wrapped);
    logic [12:0] s;
    if (now_pos >= start_pos) s = {1'b0, now_pos - start_pos};
    else                      s = {1'b0, period - start_pos + now_pos};
    if (wrapped) begin
      s = s + {1'b0, wrap_add};
      if (s >= {1'b0, period}) s = s - {1'b0, period};
    end
    return s[11:0];
  endfunction

endpackage

// ===== src/cmps_mod_const.sv =====
// ----------------------------------------------------------------------------
// Constant modulus unit
// Two-stage remainder of a 32-bit value by (DIV << SHIFT), using a
// reciprocal multiply for the quotient and a subtract for the remainder.
// ----------------------------------------------------------------------------
module cmps_mod_const #(
  parameter int unsigned SHIFT = 4,
  parameter int unsigned DIV   = 15
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic [31:0]                          value,
  output logic [$clog2(DIV)+SHIFT-1:0]         residue
);

  localparam int unsigned DW = $clog2(DIV);
  localparam int unsigned NB = 32 - SHIFT;
  localparam int unsigned S  = NB + DW;
  localparam int unsigned MW = NB + 1;
  localparam int unsigned QW = NB - DW + 1;
  localparam longint unsigned MULT_L = ((64'd1 << S) + DIV - 1) / DIV;
  localparam logic [MW-1:0] MULT = MW'(MULT_L);

  logic [NB-1:0]       hi;
  logic [NB+MW-1:0]    prod;
  logic [QW-1:0]       quot;
  logic [DW-1:0]       hi_low;
  logic [SHIFT-1:0]    lo;
  logic [QW+DW-1:0]    qd;
  logic [DW-1:0]       rem;

  assign hi   = value[31:SHIFT];
  assign prod = (NB+MW)'(hi) * (NB+MW)'(MULT);

  // The scaled reciprocal is exact for every value of the upper bits.
  always_ff @(posedge clk) begin
    if (en) begin
      quot   <= QW'(prod >> S);
      hi_low <= hi[DW-1:0];
      lo     <= value[SHIFT-1:0];
    end
  end

  assign qd  = (QW+DW)'(quot) * (QW+DW)'(DIV);
  assign rem = hi_low - qd[DW-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      residue <= {rem, lo};
    end
  end

endmodule

// ===== src/chassis_motion_pattern_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// Chassis motion pattern sequencer
// Drives four mecanum wheels and a two-servo gripper from timed motion modes.
// ----------------------------------------------------------------------------
// The block takes one input word per cycle while its output is not stalled
// and returns exactly one result word for each. Words flow through
// a four-register pipeline: an input register, a quotient register and a
// remainder register for the constant-period position of the timestamp, and
// the result register. The whole pipeline advances together whenever the
// result register is empty or its word is being taken, so a stalled output
// holds everything behind it and in_ready follows that condition only.
// The mode, phase start, one-shot flag and manual override live next to the
// last stage and are updated there, so each word sees the state left by the
// word just before it. Pattern timing uses the position of now_ms within
// each period, taken ahead of time, and the stored position of the phase
// start; their difference modulo the period, plus 2^32 modulo the period
// when now_ms is below the phase start, equals the elapsed time modulo the
// period. The device_present register is written through cfg_we and
// cfg_wdata and gates every wheel and gripper write.
// ----------------------------------------------------------------------------
module chassis_motion_pattern_sequencer_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        action,
  input  logic [3:0]        motion,
  input  logic [31:0]       now_ms,
  input  logic signed [7:0] manual_wheel_0,
  input  logic signed [7:0] manual_wheel_1,
  input  logic signed [7:0] manual_wheel_2,
  input  logic signed [7:0] manual_wheel_3,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              motor_write,
  output logic signed [7:0] wheel_0,
  output logic signed [7:0] wheel_1,
  output logic signed [7:0] wheel_2,
  output logic signed [7:0] wheel_3,
  output logic              servo_write,
  output logic [7:0]        servo_angle_a,
  output logic [7:0]        servo_angle_b,
  output logic              manual_active
);

  // Pipeline control. Every stage moves on the same enable.
  logic en;
  logic v0, v1, v2;
  cmps_pkg::item_t s0, s1, s2;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v0        <= in_valid;
      v1        <= v0;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0 <= '{action: action, motion: motion, now_ms: now_ms,
              w0: manual_wheel_0, w1: manual_wheel_1,
              w2: manual_wheel_2, w3: manual_wheel_3};
      s1 <= s0;
      s2 <= s1;
    end
  end

  // Position of the timestamp within each pattern period. Each unit splits
  // its period into a power of two and an odd factor, and lines up with s2.
  cmps_pkg::residue_t rn;

  cmps_mod_const #(.SHIFT(4), .DIV(15)) u_mod240 (
    .clk(clk), .en(en), .value(s0.now_ms), .residue(rn.r240));
  cmps_mod_const #(.SHIFT(3), .DIV(125)) u_mod1000 (
    .clk(clk), .en(en), .value(s0.now_ms), .residue(rn.r1000));
  cmps_mod_const #(.SHIFT(3), .DIV(75)) u_mod600 (
    .clk(clk), .en(en), .value(s0.now_ms), .residue(rn.r600));
  cmps_mod_const #(.SHIFT(6), .DIV(25)) u_mod1600 (
    .clk(clk), .en(en), .value(s0.now_ms), .residue(rn.r1600));
  cmps_mod_const #(.SHIFT(4), .DIV(75)) u_mod1200 (
    .clk(clk), .en(en), .value(s0.now_ms), .residue(rn.r1200));
  cmps_mod_const #(.SHIFT(5), .DIV(75)) u_mod2400 (
    .clk(clk), .en(en), .value(s0.now_ms), .residue(rn.r2400));

  // Sequencer state.
  logic               dev_present;
  logic [3:0]         cur_mode, cur_mode_next;
  logic [31:0]        phase_start, phase_start_next;
  cmps_pkg::residue_t phase_res, phase_res_next;
  logic               oneshot, oneshot_next;
  logic               override, override_next;
  logic [31:0]        deadline, deadline_next;

  // Decision signals.
  cmps_pkg::residue_t d;
  logic [31:0]        t_elapsed;
  logic               wrapped;
  logic [31:0]        since_deadline;
  logic [2:0]         beat;
  logic signed [7:0]  spin;
  logic               want_mw, want_sw;
  logic signed [7:0]  wv0, wv1, wv2, wv3;
  logic [7:0]         ang;
  logic               mw, sw;

  always_comb begin
    t_elapsed      = s2.now_ms - phase_start;
    wrapped        = s2.now_ms < phase_start;
    since_deadline = s2.now_ms - deadline;

    // Elapsed time modulo each period, from the two stored positions.
    d.r240  = 8'(cmps_pkg::period_diff(12'(rn.r240), 12'(phase_res.r240),
                                       12'(cmps_pkg::GREET_PERIOD),
                                       12'(cmps_pkg::WRAP_240), wrapped));
    d.r1000 = 10'(cmps_pkg::period_diff(12'(rn.r1000), 12'(phase_res.r1000),
                                        12'(cmps_pkg::ATTN_PERIOD),
                                        12'(cmps_pkg::WRAP_1000), wrapped));
    d.r600  = 10'(cmps_pkg::period_diff(12'(rn.r600), 12'(phase_res.r600),
                                        12'(cmps_pkg::DIZZY_PERIOD),
                                        12'(cmps_pkg::WRAP_600), wrapped));
    d.r1600 = 11'(cmps_pkg::period_diff(12'(rn.r1600), 12'(phase_res.r1600),
                                        12'(cmps_pkg::THINK_PERIOD),
                                        12'(cmps_pkg::WRAP_1600), wrapped));
    d.r1200 = 11'(cmps_pkg::period_diff(12'(rn.r1200), 12'(phase_res.r1200),
                                        12'(cmps_pkg::HEART_PERIOD),
                                        12'(cmps_pkg::WRAP_1200), wrapped));
    d.r2400 = cmps_pkg::period_diff(rn.r2400, phase_res.r2400,
                                    cmps_pkg::CELEB_PERIOD,
                                    cmps_pkg::WRAP_2400, wrapped);

    beat = cmps_pkg::beat_of(d.r2400);
    spin = '0;

    cur_mode_next    = cur_mode;
    phase_start_next = phase_start;
    phase_res_next   = phase_res;
    oneshot_next     = oneshot;
    override_next    = override;
    deadline_next    = deadline;

    want_mw = 1'b0;
    want_sw = 1'b0;
    wv0     = '0;
    wv1     = '0;
    wv2     = '0;
    wv3     = '0;
    ang     = cmps_pkg::ANGLE_CLOSED;

    case (cmps_pkg::action_t'(s2.action))
      cmps_pkg::ACT_REQUEST: begin
        if (!override && (s2.motion != cur_mode)) begin
          cur_mode_next    = s2.motion;
          phase_start_next = s2.now_ms;
          phase_res_next   = rn;
          oneshot_next     = 1'b0;
          // Resting modes stop the wheels and park the gripper on entry.
          if (s2.motion <= cmps_pkg::MODE_IDLE) begin
            want_mw = 1'b1;
            want_sw = 1'b1;
            ang     = cmps_pkg::ANGLE_MID;
          end else if (s2.motion == cmps_pkg::MODE_SLEEP) begin
            want_mw = 1'b1;
            want_sw = 1'b1;
            ang     = cmps_pkg::ANGLE_CLOSED;
          end
        end
      end
      cmps_pkg::ACT_TICK: begin
        if (dev_present && !override) begin
          case (cmps_pkg::mode_t'(cur_mode))
            cmps_pkg::MODE_GREET: begin
              if (t_elapsed >= cmps_pkg::GREET_LENGTH) begin
                if (!oneshot) begin
                  want_sw      = 1'b1;
                  ang          = cmps_pkg::ANGLE_MID;
                  oneshot_next = 1'b1;
                end
              end else begin
                want_sw = 1'b1;
                ang     = (d.r240 < cmps_pkg::GREET_HALF) ? cmps_pkg::ANGLE_OPEN
                          : cmps_pkg::ANGLE_CLOSED;
              end
            end
            cmps_pkg::MODE_ATTENTION: begin
              want_mw = 1'b1;
              if (d.r1000 < cmps_pkg::ATTN_FWD_END) begin
                wv0 = cmps_pkg::ATTN_SPEED;
                wv1 = cmps_pkg::ATTN_SPEED;
                wv2 = cmps_pkg::ATTN_SPEED;
                wv3 = cmps_pkg::ATTN_SPEED;
              end else if (d.r1000 < cmps_pkg::ATTN_BACK_END) begin
                wv0 = -cmps_pkg::ATTN_SPEED;
                wv1 = -cmps_pkg::ATTN_SPEED;
                wv2 = -cmps_pkg::ATTN_SPEED;
                wv3 = -cmps_pkg::ATTN_SPEED;
              end
            end
            cmps_pkg::MODE_CELEBRATE: begin
              // Pure spin: the mixer gives -z, z, -z, z.
              if (beat[1:0] == 2'd3) begin
                spin = cmps_pkg::CELEB_SPIN_HALF;
              end else begin
                spin = cmps_pkg::CELEB_SPIN;
              end
              if (beat[2]) begin
                spin = -spin;
              end
              want_mw = 1'b1;
              wv0     = -spin;
              wv1     = spin;
              wv2     = -spin;
              wv3     = spin;
              want_sw = 1'b1;
              ang     = beat[0] ? cmps_pkg::ANGLE_CLOSED : cmps_pkg::ANGLE_OPEN;
            end
            cmps_pkg::MODE_DIZZY: begin
              want_mw = 1'b1;
              if (t_elapsed < cmps_pkg::DIZZY_LENGTH) begin
                spin = (d.r600 < cmps_pkg::DIZZY_HALF) ? cmps_pkg::DIZZY_SPIN
                       : -cmps_pkg::DIZZY_SPIN;
                wv0  = -spin;
                wv1  = spin;
                wv2  = -spin;
                wv3  = spin;
              end
            end
            cmps_pkg::MODE_THINKING: begin
              // Pure strafe: the mixer gives x, -x, -x, x.
              want_mw = 1'b1;
              if (d.r1600 < cmps_pkg::THINK_NUDGE) begin
                wv0 = cmps_pkg::THINK_SPEED;
                wv1 = -cmps_pkg::THINK_SPEED;
                wv2 = -cmps_pkg::THINK_SPEED;
                wv3 = cmps_pkg::THINK_SPEED;
              end else if (d.r1600 >= cmps_pkg::THINK_BACK_BEG &&
                           d.r1600 < cmps_pkg::THINK_BACK_END) begin
                wv0 = -cmps_pkg::THINK_SPEED;
                wv1 = cmps_pkg::THINK_SPEED;
                wv2 = cmps_pkg::THINK_SPEED;
                wv3 = -cmps_pkg::THINK_SPEED;
              end
            end
            cmps_pkg::MODE_HEART: begin
              want_sw = 1'b1;
              ang     = (d.r1200 < cmps_pkg::HEART_HALF) ? cmps_pkg::ANGLE_OPEN
                        : cmps_pkg::ANGLE_CLOSED;
            end
            default: begin
            end
          endcase
        end
      end
      cmps_pkg::ACT_MANUAL: begin
        if (dev_present) begin
          override_next = 1'b1;
          deadline_next = s2.now_ms + cmps_pkg::MANUAL_HOLD_MS;
          want_mw       = 1'b1;
          wv0           = s2.w0;
          wv1           = s2.w1;
          wv2           = s2.w2;
          wv3           = s2.w3;
        end
      end
      cmps_pkg::ACT_MANUAL_TICK: begin
        // Wrap-safe: the deadline has passed when the signed gap is not negative.
        if (override && !since_deadline[31]) begin
          want_mw       = 1'b1;
          override_next = 1'b0;
        end
      end
      cmps_pkg::ACT_STOP: begin
        want_mw       = 1'b1;
        want_sw       = 1'b1;
        ang           = cmps_pkg::ANGLE_MID;
        cur_mode_next = cmps_pkg::MODE_OFF;
        override_next = 1'b0;
      end
      default: begin
      end
    endcase

    mw = want_mw && dev_present;
    sw = want_sw && dev_present;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dev_present <= 1'b0;
    end else if (cfg_we) begin
      dev_present <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mode    <= cmps_pkg::MODE_OFF;
      phase_start <= '0;
      phase_res   <= '0;
      oneshot     <= 1'b0;
      override    <= 1'b0;
      deadline    <= '0;
    end else if (en && v2) begin
      cur_mode    <= cur_mode_next;
      phase_start <= phase_start_next;
      phase_res   <= phase_res_next;
      oneshot     <= oneshot_next;
      override    <= override_next;
      deadline    <= deadline_next;
    end
  end

  // Result register. Fields that are not written this word read as zero.
  always_ff @(posedge clk) begin
    if (en) begin
      motor_write   <= mw;
      wheel_0       <= mw ? wv0 : 8'sd0;
      wheel_1       <= mw ? wv1 : 8'sd0;
      wheel_2       <= mw ? wv2 : 8'sd0;
      wheel_3       <= mw ? wv3 : 8'sd0;
      servo_write   <= sw;
      servo_angle_a <= sw ? ang : cmps_pkg::ANGLE_CLOSED;
      servo_angle_b <= sw ? ang : cmps_pkg::ANGLE_CLOSED;
      manual_active <= override_next;
    end
  end

endmodule

// ===== src/cmps_checker.sv =====
// ----------------------------------------------------------------------------
// Chassis motion pattern sequencer port checker
// Watches the top-level ports for result words that break the output rules.
// ----------------------------------------------------------------------------
`include "chassis_motion_pattern_sequencer_top_macros.svh"

module cmps_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic              motor_write,
  input logic signed [7:0] wheel_0,
  input logic signed [7:0] wheel_1,
  input logic signed [7:0] wheel_2,
  input logic signed [7:0] wheel_3,
  input logic              servo_write,
  input logic [7:0]        servo_angle_a,
  input logic [7:0]        servo_angle_b,
  input logic              manual_active
);

  // No word may be offered right after reset.
  `CMPS_CHECK_RESET(a_reset_empty, !out_valid, "result word offered after reset")

  // Wheels read zero in a word without a motor write.
  `CMPS_CHECK_NOW(a_wheels_quiet, out_valid && !motor_write,
    wheel_0 == 8'sd0 && wheel_1 == 8'sd0 && wheel_2 == 8'sd0 && wheel_3 == 8'sd0,
    "wheel pulse nonzero without motor write")

  // Both gripper servos always get the same legal angle.
  `CMPS_CHECK_NOW(a_angle_legal, out_valid && servo_write,
    servo_angle_a == servo_angle_b && (servo_angle_a == cmps_pkg::ANGLE_CLOSED ||
    servo_angle_a == cmps_pkg::ANGLE_MID || servo_angle_a == cmps_pkg::ANGLE_OPEN),
    "gripper angles unequal or out of set")

  // Angles read zero in a word without a servo write.
  `CMPS_CHECK_NOW(a_servo_quiet, out_valid && !servo_write,
    servo_angle_a == cmps_pkg::ANGLE_CLOSED && servo_angle_b == cmps_pkg::ANGLE_CLOSED,
    "gripper angle nonzero without servo write")

  // An untaken word stays, with write flags, wheel_0, angle a and manual stable.
  `CMPS_CHECK_NEXT(a_hold, out_valid && !out_ready,
    out_valid && $stable(motor_write) && $stable(wheel_0) && $stable(servo_write) &&
    $stable(servo_angle_a) && $stable(manual_active),
    "stalled result word changed")

endmodule

bind chassis_motion_pattern_sequencer_top cmps_checker u_checker (.*);

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for the chassis motion pattern sequencer
// Streams motion-mode requests, pattern ticks, manual drive and stop words
// into the block under random sender gaps and receiver stalls. Every result
// word is checked against a cycle-free model of the sequencer's state.
// ----------------------------------------------------------------------------
module tb_top;
  import cmps_pkg::*;

  // Action and mode codes that the package leaves without a name.
  localparam logic [2:0] ACT_UNUSED     = 3'd7;
  localparam logic [3:0] MODE_UNDEFINED = 4'd15;

  // The run is cut off here if it has not finished by then.
  localparam int CYCLE_LIMIT = 400000;

  // One result word as the block presents it on its output ports.
  typedef struct packed {
    logic              mw;
    logic signed [7:0] w0;
    logic signed [7:0] w1;
    logic signed [7:0] w2;
    logic signed [7:0] w3;
    logic              sw;
    logic [7:0]        ang_a;
    logic [7:0]        ang_b;
    logic              manual;
  } outcome_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic              cfg_wdata = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [2:0]        action = '0;
  logic [3:0]        motion = '0;
  logic [31:0]       now_ms = '0;
  logic signed [7:0] manual_wheel_0 = '0;
  logic signed [7:0] manual_wheel_1 = '0;
  logic signed [7:0] manual_wheel_2 = '0;
  logic signed [7:0] manual_wheel_3 = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              motor_write;
  logic signed [7:0] wheel_0;
  logic signed [7:0] wheel_1;
  logic signed [7:0] wheel_2;
  logic signed [7:0] wheel_3;
  logic              servo_write;
  logic [7:0]        servo_angle_a;
  logic [7:0]        servo_angle_b;
  logic              manual_active;

  chassis_motion_pattern_sequencer_top dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .motion         (motion),
    .now_ms         (now_ms),
    .manual_wheel_0 (manual_wheel_0),
    .manual_wheel_1 (manual_wheel_1),
    .manual_wheel_2 (manual_wheel_2),
    .manual_wheel_3 (manual_wheel_3),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .motor_write    (motor_write),
    .wheel_0        (wheel_0),
    .wheel_1        (wheel_1),
    .wheel_2        (wheel_2),
    .wheel_3        (wheel_3),
    .servo_write    (servo_write),
    .servo_angle_a  (servo_angle_a),
    .servo_angle_b  (servo_angle_b),
    .manual_active  (manual_active)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Sequencer state as the model sees it. These variables track the block's
  // mode, phase start, greet settle flag and manual override, plus our own
  // copy of the device_present register.
  // --------------------------------------------------------------------------
  logic [3:0]  mode_q = MODE_OFF;
  logic [31:0] phase_start_q = '0;
  logic        greet_done_q = 1'b0;
  logic        override_q = 1'b0;
  logic [31:0] deadline_q = '0;
  logic        present_q = 1'b0;

  item_t    motion_cmds[$];     // words still to be sent
  outcome_t awaited_outcomes[$]; // predictions for words already accepted

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int bad_words = 0;
  int result_count = 0;
  int cycle_count = 0;
  logic [31:0] clock_ms = 32'd0;

  // Pattern boundaries in milliseconds. Random ticks land on these, one off
  // either side, so every window edge of every pattern is exercised.
  int unsigned turn_points[19] = '{0, 120, 240, 360, 480, 200, 400, 1000, 300, 600,
                                   900, 1200, 1500, 1800, 2100, 2400, 800, 920, 1600};

  function automatic int clamp100(int v);
    if (v > 100) return 100;
    if (v < -100) return -100;
    return v;
  endfunction

  // Wheel and gripper writes only show up when the chassis is present.
  function automatic outcome_t with_wheels(outcome_t r, int a, int b, int c, int d);
    if (present_q) begin
      r.mw = 1'b1;
      r.w0 = a[7:0];
      r.w1 = b[7:0];
      r.w2 = c[7:0];
      r.w3 = d[7:0];
    end
    return r;
  endfunction

  function automatic outcome_t with_grip(outcome_t r, logic [7:0] ang);
    if (present_q) begin
      r.sw = 1'b1;
      r.ang_a = ang;
      r.ang_b = ang;
    end
    return r;
  endfunction

  // Holonomic mixer: strafe and drive are scaled down while spinning, with
  // the division truncating toward zero, then each wheel is clamped.
  function automatic outcome_t with_mix(outcome_t r, int x, int y, int z);
    int m;
    if (z != 0) begin
      m = 100 - ((z < 0) ? -z : z);
      x = (x * m) / 100;
      y = (y * m) / 100;
    end
    return with_wheels(r, clamp100(y + x - z), clamp100(y - x + z),
                       clamp100(y - x - z), clamp100(y + x + z));
  endfunction

  // Works out the result word for one accepted input word and advances the
  // model state exactly as the block is meant to.
  function automatic outcome_t sequencer_step(input item_t word_in);
    outcome_t    r;
    logic [31:0] t;
    logic [31:0] p;
    logic [31:0] beat;
    logic [31:0] lag;
    int          spin;
    r = '0;
    t = word_in.now_ms - phase_start_q;
    case (word_in.action)
      ACT_REQUEST: begin
        // A request is dropped during manual override or when it names the
        // mode already running; otherwise state changes even when absent.
        if (!override_q && word_in.motion != mode_q) begin
          mode_q = word_in.motion;
          phase_start_q = word_in.now_ms;
          greet_done_q = 1'b0;
          if (word_in.motion <= MODE_IDLE) begin
            r = with_wheels(r, 0, 0, 0, 0);
            r = with_grip(r, ANGLE_MID);
          end else if (word_in.motion == MODE_SLEEP) begin
            r = with_wheels(r, 0, 0, 0, 0);
            r = with_grip(r, ANGLE_CLOSED);
          end
        end
      end
      ACT_TICK: begin
        if (present_q && !override_q) begin
          case (mode_q)
            MODE_GREET: begin
              if (t >= 480) begin
                if (!greet_done_q) begin
                  r = with_grip(r, ANGLE_MID);
                  greet_done_q = 1'b1;
                end
              end else begin
                r = with_grip(r, (t % 240 < 120) ? ANGLE_OPEN : ANGLE_CLOSED);
              end
            end
            MODE_ATTENTION: begin
              p = t % 1000;
              if (p < 200) r = with_mix(r, 0, 50, 0);
              else if (p < 400) r = with_mix(r, 0, -50, 0);
              else r = with_wheels(r, 0, 0, 0, 0);
            end
            MODE_CELEBRATE: begin
              beat = (t / 300) % 8;
              spin = (beat < 4) ? 90 : -90;
              if (beat == 3 || beat == 7) spin = spin / 2;
              r = with_mix(r, 0, 0, spin);
              r = with_grip(r, beat[0] ? ANGLE_CLOSED : ANGLE_OPEN);
            end
            MODE_DIZZY: begin
              if (t >= 2400) r = with_wheels(r, 0, 0, 0, 0);
              else r = with_mix(r, 0, 0, (t % 600 < 300) ? 40 : -40);
            end
            MODE_THINKING: begin
              p = t % 1600;
              if (p < 120) r = with_mix(r, 30, 0, 0);
              else if (p < 800) r = with_wheels(r, 0, 0, 0, 0);
              else if (p < 920) r = with_mix(r, -30, 0, 0);
              else r = with_wheels(r, 0, 0, 0, 0);
            end
            MODE_HEART: begin
              r = with_grip(r, (t % 1200 < 600) ? ANGLE_OPEN : ANGLE_CLOSED);
            end
            default: ;
          endcase
        end
      end
      ACT_MANUAL: begin
        if (present_q) begin
          override_q = 1'b1;
          deadline_q = word_in.now_ms + 32'd1500;
          r = with_wheels(r, word_in.w0, word_in.w1, word_in.w2, word_in.w3);
        end
      end
      ACT_MANUAL_TICK: begin
        // The deadline test is a signed difference so it survives a wrap.
        if (override_q) begin
          lag = word_in.now_ms - deadline_q;
          if (!lag[31]) begin
            r = with_wheels(r, 0, 0, 0, 0);
            override_q = 1'b0;
          end
        end
      end
      ACT_STOP: begin
        r = with_wheels(r, 0, 0, 0, 0);
        r = with_grip(r, ANGLE_MID);
        mode_q = MODE_OFF;
        override_q = 1'b0;
      end
      default: ;
    endcase
    r.manual = override_q;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driver. A new word is loaded whenever the current one has been taken or
  // nothing is being offered; the prediction is made at the edge where the
  // block accepts the word, so it sees the same order the block does.
  // --------------------------------------------------------------------------
  item_t cur_cmd;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        awaited_outcomes.push_back(sequencer_step(cur_cmd));
      end
      if (!in_valid || in_ready) begin
        if (motion_cmds.size() != 0 && $urandom_range(1, 100) > send_idle_pct) begin
          cur_cmd = motion_cmds.pop_front();
          action <= cur_cmd.action;
          motion <= cur_cmd.motion;
          now_ms <= cur_cmd.now_ms;
          manual_wheel_0 <= cur_cmd.w0;
          manual_wheel_1 <= cur_cmd.w1;
          manual_wheel_2 <= cur_cmd.w2;
          manual_wheel_3 <= cur_cmd.w3;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Each accepted result word is compared field by field with the
  // oldest prediction. Only the first ten mismatches are printed.
  // --------------------------------------------------------------------------
  outcome_t got;
  outcome_t want;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {motor_write, wheel_0, wheel_1, wheel_2, wheel_3,
               servo_write, servo_angle_a, servo_angle_b, manual_active};
        if (awaited_outcomes.size() == 0) begin
          bad_words++;
          if (bad_words <= 10)
            $display("result word %0d arrived with no prediction waiting", result_count);
        end else begin
          want = awaited_outcomes.pop_front();
          if (got.mw !== want.mw || got.w0 !== want.w0 || got.w1 !== want.w1 ||
              got.w2 !== want.w2 || got.w3 !== want.w3 || got.sw !== want.sw ||
              got.ang_a !== want.ang_a || got.ang_b !== want.ang_b ||
              got.manual !== want.manual) begin
            bad_words++;
            if (bad_words <= 10) begin
              $display("result word %0d expected: mw=%0b wheels=%0d,%0d,%0d,%0d sw=%0b %0d/%0d man=%0b",
                       result_count, want.mw, want.w0, want.w1, want.w2, want.w3,
                       want.sw, want.ang_a, want.ang_b, want.manual);
              $display("result word %0d actual:   mw=%0b wheels=%0d,%0d,%0d,%0d sw=%0b %0d/%0d man=%0b",
                       result_count, got.mw, got.w0, got.w1, got.w2, got.w3,
                       got.sw, got.ang_a, got.ang_b, got.manual);
            end
          end
        end
        result_count++;
      end
      out_ready <= ($urandom_range(1, 100) > recv_stall_pct);
    end
  end

  // A hung handshake must not stall the run forever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[chassis_motion_pattern_sequencer_top] ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus. Queue work and rate changes happen on the falling edge so they
  // never race with the driver and monitor; set_present acts on the rising edge.
  // --------------------------------------------------------------------------
  task automatic push_cmd(input logic [2:0] act, input logic [3:0] mo, input logic [31:0] at,
                          input logic [7:0] p0 = 8'd0, input logic [7:0] p1 = 8'd0,
                          input logic [7:0] p2 = 8'd0, input logic [7:0] p3 = 8'd0);
    item_t w;
    w.action = act;
    w.motion = mo;
    w.now_ms = at;
    w.w0 = p0;
    w.w1 = p1;
    w.w2 = p2;
    w.w3 = p3;
    motion_cmds.push_back(w);
  endtask

  // Wait until every word has gone through and the pipeline is empty. Each
  // word makes exactly one result, so no prediction left means no word inside.
  task automatic settle();
    @(negedge clk);
    while (motion_cmds.size() != 0 || in_valid || awaited_outcomes.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_present(input logic v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    present_q = v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Elapsed time for a random tick: near a pattern edge, in the first few
  // seconds, or far out so the period arithmetic wraps many times.
  function automatic logic [31:0] tick_offset();
    logic [31:0] b;
    case ($urandom_range(0, 2))
      0: return $urandom_range(0, 3000);
      1: begin
        b = turn_points[$urandom_range(0, 18)] + 24000 * $urandom_range(0, 2);
        return b + $urandom_range(0, 2) - 1;
      end
      default: return $urandom_range(0, 200000);
    endcase
  endfunction

  // Random traffic made mostly of well-formed sequences: a mode request
  // followed by a burst of ticks, a manual drive followed by manual ticks
  // around its deadline, and stops. Random noise words are mixed in but do
  // not count toward the target.
  task automatic random_traffic(input int target);
    int          made;
    int          kind;
    int          n;
    int          k;
    logic [3:0]  m;
    logic [31:0] base;
    logic [31:0] slip;
    made = 0;
    while (made < target) begin
      kind = $urandom_range(0, 99);
      if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
      base = clock_ms;
      if (kind < 50) begin
        m = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(3, 8)) : 4'($urandom);
        push_cmd(ACT_REQUEST, m, base);
        if ($urandom_range(0, 9) == 0) push_cmd(ACT_REQUEST, m, base + 5);
        n = $urandom_range(3, 10);
        for (k = 0; k < n; k++) push_cmd(ACT_TICK, 4'($urandom), base + tick_offset());
        made += n + 1;
        clock_ms = base + $urandom_range(0, 9000);
      end else if (kind < 72) begin
        push_cmd(ACT_MANUAL, 4'($urandom), base, 8'($urandom), 8'($urandom),
                 8'($urandom), 8'($urandom));
        // Requests and ticks during the override must be ignored.
        n = $urandom_range(0, 2);
        for (k = 0; k < n; k++) begin
          if ($urandom_range(0, 1) != 0)
            push_cmd(ACT_REQUEST, 4'($urandom_range(0, 8)), base + k);
          else
            push_cmd(ACT_TICK, 4'($urandom), base + k);
        end
        made += n + 1;
        n = $urandom_range(1, 3);
        for (k = 0; k < n; k++) begin
          case ($urandom_range(0, 3))
            0: slip = 32'hFFFF_FFFF;
            1: slip = 32'd0;
            2: slip = 32'd1;
            default: slip = $urandom;
          endcase
          // The last manual tick usually lands past the deadline.
          if (k == n - 1 && $urandom_range(0, 4) != 0) slip = $urandom_range(0, 400);
          push_cmd(ACT_MANUAL_TICK, 4'($urandom), base + 32'd1500 + slip);
        end
        made += n;
        clock_ms = base + 32'd1500 + $urandom_range(0, 3000);
      end else if (kind < 80) begin
        push_cmd(ACT_STOP, 4'($urandom), base);
        made++;
      end else if (kind < 90) begin
        push_cmd(3'($urandom), 4'($urandom), $urandom, 8'($urandom), 8'($urandom),
                 8'($urandom), 8'($urandom));
      end else begin
        push_cmd(ACT_REQUEST, 4'($urandom_range(0, 2)), base);
        made++;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Device absent after reset: the mode still changes but nothing is
    // written, and manual drive is refused.
    push_cmd(ACT_REQUEST, MODE_SLEEP, 32'd0);
    push_cmd(ACT_MANUAL, MODE_OFF, 32'd20, 8'd5, 8'd5, 8'd5, 8'd5);
    push_cmd(ACT_MANUAL_TICK, MODE_OFF, 32'd1600);
    push_cmd(ACT_STOP, MODE_OFF, 32'd30);
    settle();

    // Directed walk through every pattern with the device present.
    set_present(1'b1);
    push_cmd(ACT_REQUEST, MODE_GREET, 32'd1000);
    push_cmd(ACT_TICK, MODE_OFF, 32'd1000);
    push_cmd(ACT_TICK, MODE_OFF, 32'd1119);
    push_cmd(ACT_TICK, MODE_OFF, 32'd1120);
    push_cmd(ACT_TICK, MODE_OFF, 32'd1480);   // greet settles once
    push_cmd(ACT_TICK, MODE_OFF, 32'd1481);   // and stays quiet after
    push_cmd(ACT_REQUEST, MODE_GREET, 32'd1700);
    push_cmd(ACT_REQUEST, MODE_ATTENTION, 32'd5000);
    push_cmd(ACT_TICK, MODE_OFF, 32'd5250);
    push_cmd(ACT_REQUEST, MODE_CELEBRATE, 32'd0);
    push_cmd(ACT_TICK, MODE_OFF, 32'd900);    // halved spin on beat three
    push_cmd(ACT_REQUEST, MODE_DIZZY, 32'd10);
    push_cmd(ACT_TICK, MODE_OFF, 32'd2409);
    push_cmd(ACT_TICK, MODE_OFF, 32'd2410);
    // Phase start just below the wrap point; the tick lands after it.
    push_cmd(ACT_REQUEST, MODE_THINKING, 32'hFFFF_FF00);
    push_cmd(ACT_TICK, MODE_OFF, 32'h0000_0220);
    push_cmd(ACT_REQUEST, MODE_HEART, 32'd0);
    push_cmd(ACT_TICK, MODE_OFF, 32'd599);
    push_cmd(ACT_MANUAL, MODE_OFF, 32'd100, 8'h80, 8'h7F, 8'hFF, 8'h00);
    push_cmd(ACT_REQUEST, MODE_IDLE, 32'd200);
    push_cmd(ACT_MANUAL_TICK, MODE_OFF, 32'd1599);
    push_cmd(ACT_MANUAL_TICK, MODE_OFF, 32'd1600);
    push_cmd(ACT_REQUEST, MODE_UNDEFINED, 32'd0);
    push_cmd(ACT_UNUSED, MODE_OFF, 32'd0);
    push_cmd(ACT_REQUEST, MODE_SLEEP, 32'd0);
    push_cmd(ACT_REQUEST, MODE_OFF, 32'd0);
    push_cmd(ACT_STOP, MODE_OFF, 32'hFFFF_FFFF);
    settle();

    // Random phases: free flow, a starved sender, a stalled receiver with the
    // device absent, both sides idling, and free flow again.
    random_traffic(300);
    settle();
    send_idle_pct = 66;
    random_traffic(250);
    settle();
    send_idle_pct = 0;
    recv_stall_pct = 66;
    set_present(1'b0);
    random_traffic(100);
    settle();
    set_present(1'b1);
    send_idle_pct = 28;
    recv_stall_pct = 28;
    random_traffic(300);
    settle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_traffic(100);
    settle();

    if (bad_words == 0 && awaited_outcomes.size() == 0) begin
      $display("[chassis_motion_pattern_sequencer_top] OK");
    end else begin
      $display("[chassis_motion_pattern_sequencer_top] ERROR");
    end
    $finish;
  end

endmodule
